// ===== src/bdhr_pkg.sv =====
// Shared constants for the button debounce / hold / auto-repeat block.
// No dependencies; imported by button_debounce_hold_repeat.
`timescale 1ns / 1ps

package bdhr_pkg;

  // Width of the elapsed-time counters (valid from 8 to 32)
  localparam int unsigned CounterWidth = 16;
  // Width of every configuration register
  localparam int unsigned CfgWidth     = 16;
  // Common width for counter versus register compares
  localparam int unsigned CmpWidth     =
      (CounterWidth > CfgWidth) ? CounterWidth : CfgWidth;

  // Configuration register indexes
  localparam int unsigned CfgIdxWidth = 3;
  localparam logic [CfgIdxWidth-1:0] CfgDebounce = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgHold     = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgInitial  = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgSlow     = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgFast     = 3'd4;

  // Configuration reset values
  localparam logic [CfgWidth-1:0] DebounceReset = 16'd50;
  localparam logic [CfgWidth-1:0] HoldReset     = 16'd1000;
  localparam logic [CfgWidth-1:0] InitialReset  = 16'd300;
  localparam logic [CfgWidth-1:0] SlowReset     = 16'd150;
  localparam logic [CfgWidth-1:0] FastReset     = 16'd50;

  // Repeat count and interval selection
  localparam logic [2:0] RepeatMax  = 3'd7;
  localparam logic [2:0] SlowAfter  = 3'd3;
  localparam logic [2:0] FastAfter  = 3'd5;

  localparam logic [1:0] SelInitial = 2'd0;
  localparam logic [1:0] SelSlow    = 2'd1;
  localparam logic [1:0] SelFast    = 2'd2;

  typedef logic [CounterWidth-1:0] cnt_t;

  // Saturating increment of an elapsed-time counter
  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == '1) ? v : v + cnt_t'(1);
  endfunction

endpackage

// ===== src/button_debounce_hold_repeat.sv =====
// Button debounce with hold detection and accelerating auto-repeat.
// Depends on bdhr_pkg (counter width, register indexes, codes).
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one tick item per
//   accepted handshake: the raw active-low pin level and a request to
//   restart the repeat sequence. Output channel (out_valid_o /
//   out_ready_i) returns exactly one result item per tick: debounced
//   level, press pulse, hold flag and repeat pulse.
//   Latency: the result is valid the cycle after the item is accepted.
//   Throughput: one item per cycle while the receiver takes results;
//   all state updates for a tick are done in one combinational pass
//   between the state registers and the result register.
//   Stall: while a result waits, a new item is still taken if the
//   receiver takes the held result in the same cycle; otherwise
//   in_ready_o drops until the result register frees.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
//   (0 debounce, 1 hold, 2 initial, 3 slow, 4 fast interval) at once;
//   other indexes are ignored. Write only while the block is idle.
//   Reset: registers take their default values, the level reads as
//   released, all counters clear and no result is pending.

module button_debounce_hold_repeat (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tick items
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              raw_level_i,
  input  logic                              restart_repeat_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              stable_level_o,
  output logic                              press_event_o,
  output logic                              holding_o,
  output logic                              repeat_event_o,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [bdhr_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [bdhr_pkg::CfgWidth-1:0]     cfg_data_i
);
  import bdhr_pkg::*;

  // configuration registers
  logic [CfgWidth-1:0] debounce_q, hold_ticks_q, initial_q, slow_q, fast_q;

  // tick state
  logic       prev_raw_q, prev_raw_d;
  logic       debounced_q, debounced_d;
  cnt_t       since_change_q, since_change_d;
  cnt_t       since_press_q, since_press_d;
  cnt_t       since_action_q, since_action_d;
  logic       hold_q, hold_d;
  logic [2:0] rep_cnt_q, rep_cnt_d;
  logic [1:0] sel_q, sel_d;

  // result register
  logic out_valid_q;
  logic stable_q, press_q, holding_q, repeat_q;
  logic press_d, repeat_d;

  logic                in_fire;
  logic [CfgWidth-1:0] interval;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_fire    = in_valid_i & in_ready_o;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DebounceReset;
      hold_ticks_q <= HoldReset;
      initial_q    <= InitialReset;
      slow_q       <= SlowReset;
      fast_q       <= FastReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgDebounce: debounce_q   <= cfg_data_i;
        CfgHold:     hold_ticks_q <= cfg_data_i;
        CfgInitial:  initial_q    <= cfg_data_i;
        CfgSlow:     slow_q       <= cfg_data_i;
        CfgFast:     fast_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Compute the next state of one tick in a single pass
  always_comb begin
    // advance counters, restart change timer on an edge of the raw level
    since_change_d = sat_inc(since_change_q);
    since_press_d  = sat_inc(since_press_q);
    since_action_d = sat_inc(since_action_q);
    if (raw_level_i != prev_raw_q) begin
      since_change_d = '0;
    end

    debounced_d = debounced_q;
    hold_d      = hold_q;
    rep_cnt_d   = rep_cnt_q;
    sel_d       = sel_q;
    press_d     = 1'b0;
    repeat_d    = 1'b0;

    // accept a stable raw level
    if ((CmpWidth'(since_change_d) >= CmpWidth'(debounce_q))
        && (raw_level_i != debounced_q)) begin
      debounced_d = raw_level_i;
      hold_d      = 1'b0;
      if (!raw_level_i) begin
        press_d        = 1'b1;
        rep_cnt_d      = '0;
        sel_d          = SelInitial;
        since_press_d  = '0;
        since_action_d = '0;
      end
    end

    // declare hold once the press has lasted long enough
    if (!debounced_d && !hold_d
        && (CmpWidth'(since_press_d) >= CmpWidth'(hold_ticks_q))) begin
      hold_d         = 1'b1;
      since_action_d = '0;
    end

    // pick the current repeat interval
    unique case (sel_d)
      SelInitial: interval = initial_q;
      SelSlow:    interval = slow_q;
      default:    interval = fast_q;
    endcase

    // fire a repeat when the interval has elapsed
    if (hold_d && (CmpWidth'(since_action_d) >= CmpWidth'(interval))) begin
      since_action_d = '0;
      repeat_d       = 1'b1;
      if (rep_cnt_d != RepeatMax) begin
        rep_cnt_d = rep_cnt_d + 3'd1;
      end
      if (rep_cnt_d >= FastAfter) begin
        sel_d = SelFast;
      end else if (rep_cnt_d >= SlowAfter) begin
        sel_d = SelSlow;
      end
    end

    // restart the repeat sequence on request
    if (restart_repeat_i) begin
      rep_cnt_d = '0;
      sel_d     = SelInitial;
    end

    prev_raw_d = raw_level_i;
  end

  // Update tick state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_raw_q     <= 1'b1;
      debounced_q    <= 1'b1;
      since_change_q <= '0;
      since_press_q  <= '0;
      since_action_q <= '0;
      hold_q         <= 1'b0;
      rep_cnt_q      <= '0;
      sel_q          <= SelInitial;
    end else if (in_fire) begin
      prev_raw_q     <= prev_raw_d;
      debounced_q    <= debounced_d;
      since_change_q <= since_change_d;
      since_press_q  <= since_press_d;
      since_action_q <= since_action_d;
      hold_q         <= hold_d;
      rep_cnt_q      <= rep_cnt_d;
      sel_q          <= sel_d;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stable_q  <= debounced_d;
      press_q   <= press_d;
      holding_q <= hold_d;
      repeat_q  <= repeat_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign stable_level_o = stable_q;
  assign press_event_o  = press_q;
  assign holding_o      = holding_q;
  assign repeat_event_o = repeat_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for button_debounce_hold_repeat: directed and random tick streams.
// Depends on bdhr_pkg and the button_debounce_hold_repeat RTL.

module testbench;
  import bdhr_pkg::*;

  typedef logic [CfgWidth-1:0] reg_t;

  typedef struct packed {
    logic stable_level;
    logic press_event;
    logic holding;
    logic repeat_event;
  } tick_result_t;

  // Ports of the block
  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   in_valid       = 1'b0;
  logic                   in_ready;
  logic                   raw_level      = 1'b1;
  logic                   restart_repeat = 1'b0;
  logic                   out_valid;
  logic                   out_ready      = 1'b0;
  logic                   stable_level;
  logic                   press_event;
  logic                   holding;
  logic                   repeat_event;
  logic                   cfg_we         = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_index      = CfgDebounce;
  reg_t                   cfg_data       = '0;

  button_debounce_hold_repeat dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .raw_level_i      (raw_level),
    .restart_repeat_i (restart_repeat),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .stable_level_o   (stable_level),
    .press_event_o    (press_event),
    .holding_o        (holding),
    .repeat_event_o   (repeat_event),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Button predictor: register copies and tick state
  reg_t       debounce_lim = DebounceReset;
  reg_t       hold_lim     = HoldReset;
  reg_t       initial_ival = InitialReset;
  reg_t       slow_ival    = SlowReset;
  reg_t       fast_ival    = FastReset;
  logic       last_raw     = 1'b1;
  logic       level        = 1'b1;
  cnt_t       since_change = '0;
  cnt_t       since_press  = '0;
  cnt_t       since_action = '0;
  logic       hold_on      = 1'b0;
  logic [2:0] repeats      = '0;
  logic [1:0] ival_sel     = SelInitial;

  tick_result_t expected_results[$];
  int unsigned  mismatches  = 0;
  int unsigned  items_sent  = 0;
  int unsigned  burst_left  = 0;

  function automatic cnt_t bump(input cnt_t c);
    return (&c) ? c : c + 1'b1;
  endfunction

  // Advance the button by one tick and return what it reports
  function automatic tick_result_t step_button(input logic raw, input logic restart);
    reg_t ival;
    logic pressed_now;
    logic fired;
    pressed_now = 1'b0;
    fired       = 1'b0;
    since_change = bump(since_change);
    since_press  = bump(since_press);
    since_action = bump(since_action);
    if (raw != last_raw) since_change = '0;
    // accept a level that stayed put long enough
    if (since_change >= debounce_lim && raw != level) begin
      level   = raw;
      hold_on = 1'b0;
      if (!raw) begin
        pressed_now  = 1'b1;
        repeats      = '0;
        ival_sel     = SelInitial;
        since_press  = '0;
        since_action = '0;
      end
    end
    // declare holding once the press has lasted
    if (!level && !hold_on && since_press >= hold_lim) begin
      hold_on      = 1'b1;
      since_action = '0;
    end
    case (ival_sel)
      SelInitial: ival = initial_ival;
      SelSlow:    ival = slow_ival;
      default:    ival = fast_ival;
    endcase
    // fire a repeat when the interval has elapsed
    if (hold_on && since_action >= ival) begin
      since_action = '0;
      fired        = 1'b1;
      if (repeats != RepeatMax) repeats = repeats + 1'b1;
      if (repeats >= FastAfter) ival_sel = SelFast;
      else if (repeats >= SlowAfter) ival_sel = SelSlow;
    end
    if (restart) begin
      repeats  = '0;
      ival_sel = SelInitial;
    end
    last_raw = raw;
    return '{level, pressed_now, hold_on, fired};
  endfunction

  // Send one tick item; bursts of random length, mostly with random gaps in between
  task automatic send_tick(input logic raw, input logic restart);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    raw_level      <= raw;
    restart_repeat <= restart;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    expected_results.push_back(step_button(raw, restart));
    items_sent++;
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Write all five registers back to back; call only while idle
  task automatic set_config(input reg_t deb, input reg_t hold, input reg_t ini,
                            input reg_t slow, input reg_t fast);
    reg_t values[5];
    values = '{deb, hold, ini, slow, fast};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CfgIdxWidth'(i);
      cfg_data  <= values[i];
      @(posedge clk_i);
    end
    cfg_we       <= 1'b0;
    debounce_lim = deb;
    hold_lim     = hold;
    initial_ival = ini;
    slow_ival    = slow;
    fast_ival    = fast;
    @(posedge clk_i);
  endtask

  // Receiver: switch between always ready, random stalls and a rotating pattern
  int unsigned ready_mode    = 0;
  int unsigned mode_left     = 0;
  logic [7:0]  ready_pattern = 8'b1011_0111;

  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      mode_left     = $urandom_range(16, 96);
      ready_mode    = $urandom_range(0, 2);
      ready_pattern = 8'($urandom);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: begin
        out_ready     <= ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
      end
    endcase
  end

  // Compare each result item with the oldest expectation
  always @(posedge clk_i) begin : check_result
    tick_result_t got;
    tick_result_t want;
    if (rst_ni && out_valid && out_ready) begin
      got = '{stable_level, press_event, holding, repeat_event};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result item with nothing expected: %b", got);
      end else begin
        want = expected_results.pop_front();
        if (got.stable_level !== want.stable_level || got.press_event !== want.press_event ||
            got.holding !== want.holding || got.repeat_event !== want.repeat_event) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: level %b/%b press %b/%b hold %b/%b repeat %b/%b (exp/got)",
                     want.stable_level, got.stable_level, want.press_event,
                     got.press_event, want.holding, got.holding,
                     want.repeat_event, got.repeat_event);
        end
      end
    end
  end

  // Reset values: a short press never reaches the default debounce time
  task automatic test_reset_defaults();
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    drain();
  endtask

  // Zero debounce and hold: press and hold start at once, repeats follow at interval 1
  task automatic test_zero_thresholds();
    set_config(16'd0, 16'd0, 16'd1, 16'd1, 16'd1);
    for (int i = 0; i < 7; i++) send_tick(1'b0, logic'(i == 4));
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    drain();
  endtask

  // Zero interval fires on every holding tick; widest interval never does
  task automatic test_zero_interval();
    set_config(16'd0, 16'd2, 16'd0, 16'd1, 16'hFFFF);
    for (int i = 0; i < 5; i++) send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    drain();
  endtask

  // Bouncing level: only a level held for the debounce time is taken
  task automatic test_bounce();
    logic [9:0] bounce_seq;
    bounce_seq = 10'b01010000_11;
    set_config(16'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int i = 9; i >= 0; i--) send_tick(bounce_seq[i], 1'b0);
    drain();
  endtask

  // Widest debounce: a steady press is not taken within a short run
  task automatic test_saturation();
    set_config(16'hFFFF, 16'd0, 16'd1, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 40; i++) send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    drain();
  endtask

  // Pick a register value: mostly small, now and then an extreme
  function automatic reg_t pick_reg(input int unsigned lo, input int unsigned hi);
    case ($urandom_range(0, 11))
      0:       return reg_t'(lo);
      1:       return 16'hFFFF;
      default: return reg_t'($urandom_range(lo, hi));
    endcase
  endfunction

  // Random phases of presses with bounce, holds, repeats and restarts
  task automatic test_random();
    int unsigned start_items;
    int unsigned hold_len;
    int unsigned rel_len;
    start_items = items_sent;
    while (items_sent - start_items < 480) begin
      set_config(pick_reg(0, 6), pick_reg(0, 20), pick_reg(1, 8), pick_reg(1, 8),
                 pick_reg(1, 8));
      if ($urandom_range(0, 5) == 0) begin
        // noise only
        repeat ($urandom_range(10, 40))
          send_tick(logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(2, 5)) begin
          repeat ($urandom_range(0, 3))
            send_tick(logic'($urandom_range(0, 1)), logic'($urandom_range(0, 7) == 0));
          hold_len = debounce_lim + hold_lim + $urandom_range(1, 30);
          if (hold_len > 90) hold_len = $urandom_range(40, 90);
          repeat (hold_len) send_tick(1'b0, logic'($urandom_range(0, 15) == 0));
          repeat ($urandom_range(0, 3))
            send_tick(logic'($urandom_range(0, 1)), 1'b0);
          rel_len = debounce_lim + $urandom_range(1, 8);
          if (rel_len > 40) rel_len = $urandom_range(5, 40);
          repeat (rel_len) send_tick(1'b1, logic'($urandom_range(0, 15) == 0));
        end
      end
      drain();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_zero_thresholds();
    test_zero_interval();
    test_bounce();
    test_saturation();
    test_random();
    drain();
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
